// File: hdl/lzss_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the LZSS ring decompressor.
package lzss_pkg;
	localparam int unsigned WIN_AW = 12;
	localparam int unsigned LIMIT_W = 24;
	localparam logic [3:0] LEN_CODE_EXT = 4'hF;
	localparam logic [8:0] LEN_EXTENDED = 9'd18;
	localparam logic [8:0] LEN_BASE = 9'd3;
	localparam logic [LIMIT_W-1:0] LIMIT_RESET = 24'hFFFFFF;

	typedef enum logic [1:0] {
		PH_TOKEN = 2'd0,
		PH_CODE  = 2'd1,
		PH_EXT   = 2'd2,
		PH_SPARE = 2'd3
	} phase_t;

	// Copy request from the parser to the copy engine.
	typedef struct packed {
		logic              start;
		logic [WIN_AW-1:0] src;
		logic [8:0]        len;
	} copy_req_t;
endpackage

// File: hdl/lzss_copy.sv
`timescale 1ns / 1ps
// Ring memory and byte-serial copy engine with output packing.
module lzss_copy #(
	parameter int LANE_BYTES = 8
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  lzss_pkg::copy_req_t                 req,
	input  logic                                lit_we,
	input  logic [7:0]                          lit_byte,
	input  logic [lzss_pkg::LIMIT_W-1:0]        output_limit,
	input  logic                                cnt_clear,
	output logic                                busy,
	output logic                                res_valid,
	input  logic                                res_take,
	output logic [LANE_BYTES*8-1:0]             res_bytes,
	output logic [3:0]                          res_count,
	output logic                                res_last
);
	localparam int FW = $clog2(LANE_BYTES + 1);

	logic [7:0] mem [0:(1<<lzss_pkg::WIN_AW)-1];
	logic [lzss_pkg::WIN_AW-1:0] wpos_q, src_q;
	logic [8:0] left_q;
	logic       run_q, rd_q;
	logic [7:0] rdata_q;
	logic [LANE_BYTES*8-1:0] acc_q;
	logic [FW-1:0] fill_q;
	logic [lzss_pkg::LIMIT_W-1:0] cnt_q;
	logic       clr_run_q;
	logic [lzss_pkg::WIN_AW-1:0] clr_addr_q;
	logic       end_clr_q;

	logic can_go, fetch, out_full, lim_hit;
	logic [FW-1:0] fill_n;

	assign lim_hit = cnt_q >= output_limit;
	assign out_full = res_valid && !res_take;
	// One byte in flight: fetch, then store and pack on the next cycle.
	assign fetch = run_q && !rd_q && left_q != 9'd0 && !lim_hit && !out_full;
	assign fill_n = fill_q + FW'(1);
	assign busy = run_q || rd_q || clr_run_q;
	assign can_go = 1'b0;

	always_ff @(posedge clk) begin
		if (clr_run_q)
			mem[clr_addr_q] <= 8'h00;
		else if (lit_we)
			mem[wpos_q] <= lit_byte;
		else if (rd_q)
			mem[wpos_q] <= rdata_q;
		if (fetch)
			rdata_q <= mem[src_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wpos_q <= '0;
			src_q <= '0;
			left_q <= '0;
			run_q <= 1'b0;
			rd_q <= 1'b0;
			acc_q <= '0;
			fill_q <= '0;
			cnt_q <= '0;
			clr_run_q <= 1'b1;
			clr_addr_q <= '0;
			end_clr_q <= 1'b0;
			res_valid <= 1'b0;
			res_bytes <= '0;
			res_count <= '0;
			res_last <= 1'b0;
		end else begin
			// The ring is zeroed one entry per cycle after reset.
			if (clr_run_q) begin
				clr_addr_q <= clr_addr_q + 1'b1;
				if (&clr_addr_q)
					clr_run_q <= 1'b0;
			end
			if (res_take)
				res_valid <= 1'b0;
			if (lit_we) begin
				wpos_q <= wpos_q + 1'b1;
				if (!lim_hit) begin
					cnt_q <= cnt_q + 1'b1;
					res_valid <= 1'b1;
					res_bytes <= {{(LANE_BYTES*8-8){1'b0}}, lit_byte};
					res_count <= 4'd1;
					res_last <= 1'b1;
				end
			end
			if (req.start) begin
				src_q <= req.src;
				left_q <= req.len;
				run_q <= 1'b1;
				acc_q <= '0;
				fill_q <= '0;
				end_clr_q <= cnt_clear;
			end
			if (fetch) begin
				rd_q <= 1'b1;
				src_q <= src_q + 1'b1;
				left_q <= left_q - 1'b1;
				cnt_q <= cnt_q + 1'b1;
			end
			if (rd_q) begin
				rd_q <= 1'b0;
				wpos_q <= wpos_q + 1'b1;
				if (fill_n == FW'(LANE_BYTES)) begin
					res_valid <= 1'b1;
					res_bytes <= acc_q | ((LANE_BYTES*8)'(rdata_q) << (8 * fill_q));
					res_count <= 4'(fill_n);
					res_last <= (left_q == 9'd0) || lim_hit;
					acc_q <= '0;
					fill_q <= '0;
				end else begin
					acc_q <= acc_q | ((LANE_BYTES*8)'(rdata_q) << (8 * fill_q));
					fill_q <= fill_n;
				end
			end
			// Copy is over: flush any partial word once the output is free.
			if (run_q && !rd_q && (left_q == 9'd0 || lim_hit) && !out_full) begin
				run_q <= 1'b0;
				if (fill_q != '0) begin
					res_valid <= 1'b1;
					res_bytes <= acc_q;
					res_count <= 4'(fill_q);
					res_last <= 1'b1;
				end
				// A match that ended the call clears the count only once it is done.
				if (end_clr_q) begin
					cnt_q <= '0;
					end_clr_q <= 1'b0;
				end
			end
			if (cnt_clear && !req.start)
				cnt_q <= '0;
		end
	end
endmodule

// File: hdl/lzss_ring_decompressor.sv
`timescale 1ns / 1ps
// Top level of the LZSS ring decompressor: token parser and copy engine.
//
//  Channel   Direction  Handshake            Payload
//  in        in         in_valid/in_ready    in_byte, last_in_call
//  out       out        out_valid/out_ready  out_bytes, byte_count, last_of_run
//  cfg       in         cfg_we               cfg_data (output_limit)
//
// Every byte (flag, position, code or literal) is taken only while the engine is idle and the
// output register is free. A match copies one byte at a time through the single ring port pair
// (read, then write), fetching a byte only once the one before is written; input is held off.
// Reset clears the parser, write position and count, and then the ring is cleared to zero,
// one entry per cycle, while input is held off.
// A stalled output holds the copy engine in place.
module lzss_ring_decompressor #(
	parameter int LANE_BYTES = 8
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic [7:0]                 in_byte,
	input  logic                       last_in_call,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic [63:0]                out_bytes,
	output logic [3:0]                 byte_count,
	output logic                       last_of_run,
	input  logic                       cfg_we,
	input  logic [23:0]                cfg_data
);
	logic [23:0] limit_q;
	logic [8:0]  flags_q;
	lzss_pkg::phase_t phase_q;
	logic [7:0]  pos_lo_q, code_q;
	logic        busy, acc, lit_we, cnt_clear;
	lzss_pkg::copy_req_t req;
	logic [LANE_BYTES*8-1:0] rb;

	// A literal needs the output register; other bytes wait for it too, and all need the engine idle.
	assign in_ready = !busy && !out_valid;
	assign acc = in_valid && in_ready;

	always_comb begin
		req = '0;
		lit_we = 1'b0;
		unique case (phase_q)
			lzss_pkg::PH_CODE: begin
				req.src = {in_byte[3:0], pos_lo_q};
				req.len = {5'd0, in_byte[7:4]} + lzss_pkg::LEN_BASE;
				req.start = acc && in_byte[7:4] != lzss_pkg::LEN_CODE_EXT;
			end
			lzss_pkg::PH_EXT: begin
				req.src = {code_q[3:0], pos_lo_q};
				req.len = lzss_pkg::LEN_EXTENDED + {1'b0, in_byte};
				req.start = acc;
			end
			default: lit_we = acc && flags_q > 9'd1 && !flags_q[0];
		endcase
	end
	assign cnt_clear = acc && last_in_call;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= lzss_pkg::LIMIT_RESET;
			flags_q <= '0;
			phase_q <= lzss_pkg::PH_TOKEN;
			pos_lo_q <= '0;
			code_q <= '0;
		end else begin
			if (cfg_we)
				limit_q <= cfg_data;
			if (acc) begin
				unique case (phase_q)
					lzss_pkg::PH_CODE: begin
						code_q <= in_byte;
						phase_q <= (in_byte[7:4] == lzss_pkg::LEN_CODE_EXT) ?
							lzss_pkg::PH_EXT : lzss_pkg::PH_TOKEN;
					end
					lzss_pkg::PH_EXT: phase_q <= lzss_pkg::PH_TOKEN;
					default: begin
						phase_q <= lzss_pkg::PH_TOKEN;
						if (flags_q <= 9'd1) begin
							flags_q <= {1'b1, in_byte};
						end else begin
							flags_q <= flags_q >> 1;
							if (flags_q[0]) begin
								pos_lo_q <= in_byte;
								phase_q <= lzss_pkg::PH_CODE;
							end
						end
					end
				endcase
				if (last_in_call) begin
					flags_q <= '0;
					phase_q <= lzss_pkg::PH_TOKEN;
					pos_lo_q <= '0;
					code_q <= '0;
				end
			end
		end
	end

	lzss_copy #(.LANE_BYTES(LANE_BYTES)) u_copy (
		.clk(clk), .arst_n(arst_n), .req(req), .lit_we(lit_we), .lit_byte(in_byte),
		.output_limit(limit_q), .cnt_clear(cnt_clear), .busy(busy),
		.res_valid(out_valid), .res_take(out_valid && out_ready), .res_bytes(rb),
		.res_count(byte_count), .res_last(last_of_run)
	);
	assign out_bytes = 64'(rb);
endmodule

// File: dv/tb_top.sv
`timescale 1ns / 1ps
// Testbench for the LZSS ring decompressor: random and directed streams, self-checking.
module tb_top;
	localparam int RING_SIZE = 4096;
	localparam int SETTLE_CYCLES = 700;
	localparam int QUIET_LIMIT = 20000;

	typedef struct {
		logic [63:0] bytes;
		logic [3:0]  cnt;
		logic        lst;
	} packed_out_t;

	// The scoreboard carries its own copy of the decoder state and the queue of
	// packed outputs that the block still owes.
	class lzss_scoreboard;
		logic [7:0]                   ring [RING_SIZE];
		logic [lzss_pkg::WIN_AW-1:0]  wr_pos;
		logic [8:0]                   flags;
		lzss_pkg::phase_t             phase;
		logic [7:0]                   pos_low;
		logic [7:0]                   code;
		logic [lzss_pkg::LIMIT_W-1:0] emitted;
		logic [lzss_pkg::LIMIT_W-1:0] limit;
		packed_out_t                  owed [$];
		int                           mismatches;

		function void clear();
			foreach (ring[k]) ring[k] = 8'h00;
			wr_pos = '0;
			flags = '0;
			phase = lzss_pkg::PH_TOKEN;
			pos_low = '0;
			code = '0;
			emitted = '0;
			limit = lzss_pkg::LIMIT_RESET;
			mismatches = 0;
		endfunction

		function void push(logic [63:0] bytes, logic [3:0] cnt);
			packed_out_t r;
			r.bytes = bytes;
			r.cnt = cnt;
			r.lst = 1'b0;
			owed.push_back(r);
		endfunction

		// Copy a match out of the ring, packing up to eight bytes per output.
		function void copy_match(int unsigned len);
			logic [lzss_pkg::WIN_AW-1:0] src;
			logic [63:0] acc;
			int fill;
			logic [7:0] c;
			src = {code[3:0], pos_low};
			acc = '0;
			fill = 0;
			for (int k = 0; k < len; k++) begin
				if (emitted >= limit)
					break;
				c = ring[src];
				ring[wr_pos] = c;
				src++;
				wr_pos++;
				emitted++;
				acc[8*fill +: 8] = c;
				fill++;
				if (fill == 8) begin
					push(acc, 4'(fill));
					acc = '0;
					fill = 0;
				end
			end
			if (fill > 0)
				push(acc, 4'(fill));
		endfunction

		function void note_input(logic [7:0] b, logic last);
			int first;
			logic bit0;
			first = owed.size();
			case (phase)
				lzss_pkg::PH_CODE: begin
					code = b;
					if (b[7:4] == lzss_pkg::LEN_CODE_EXT) begin
						phase = lzss_pkg::PH_EXT;
					end else begin
						phase = lzss_pkg::PH_TOKEN;
						copy_match(int'(b[7:4]) + int'(lzss_pkg::LEN_BASE));
					end
				end
				lzss_pkg::PH_EXT: begin
					phase = lzss_pkg::PH_TOKEN;
					copy_match(int'(lzss_pkg::LEN_EXTENDED) + int'(b));
				end
				default: begin
					phase = lzss_pkg::PH_TOKEN;
					if (flags <= 9'd1) begin
						flags = {1'b1, b};
					end else begin
						bit0 = flags[0];
						flags = flags >> 1;
						if (bit0) begin
							pos_low = b;
							phase = lzss_pkg::PH_CODE;
						end else begin
							ring[wr_pos] = b;
							wr_pos++;
							if (emitted < limit) begin
								emitted++;
								push({56'h0, b}, 4'd1);
							end
						end
					end
				end
			endcase
			if (owed.size() > first)
				owed[owed.size() - 1].lst = 1'b1;
			if (last) begin
				flags = '0;
				phase = lzss_pkg::PH_TOKEN;
				pos_low = '0;
				code = '0;
				emitted = '0;
			end
		endfunction

		function void check(logic [63:0] bytes, logic [3:0] cnt, logic lst);
			packed_out_t e;
			if (owed.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("ERROR: unexpected output bytes=%h count=%0d last=%b",
						bytes, cnt, lst);
				return;
			end
			e = owed.pop_front();
			if (bytes !== e.bytes || cnt !== e.cnt || lst !== e.lst) begin
				mismatches++;
				if (mismatches <= 10)
					$display("ERROR: expected bytes=%h count=%0d last=%b, got %h %0d %b",
						e.bytes, e.cnt, e.lst, bytes, cnt, lst);
			end
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic [7:0]  in_byte;
	logic        last_in_call;
	logic        out_valid;
	logic        out_ready;
	logic [63:0] out_bytes;
	logic [3:0]  byte_count;
	logic        last_of_run;
	logic        cfg_we;
	logic [23:0] cfg_data;

	lzss_scoreboard sb;
	int send_idle_pct;
	int stall_pct;
	int hold_cycles;
	int quiet;

	lzss_ring_decompressor DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_byte(in_byte),
		.last_in_call(last_in_call),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_bytes(out_bytes),
		.byte_count(byte_count),
		.last_of_run(last_of_run),
		.cfg_we(cfg_we),
		.cfg_data(cfg_data)
	);

	initial clk = 1'b0;
	always #2 clk = ~clk;

	// Receiver side: random stalls, or a long counted hold-off when one is requested.
	always @(posedge clk) begin
		if (hold_cycles > 0) begin
			hold_cycles <= hold_cycles - 1;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(99) >= stall_pct);
		end
	end

	// Both channels are sampled at the edge, before any driven value changes.
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready)
				sb.note_input(in_byte, last_in_call);
			if (out_valid && out_ready)
				sb.check(out_bytes, byte_count, last_of_run);
		end
	end

	// The watchdog ends a run that has stopped making progress.
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			quiet <= 0;
		else
			quiet <= quiet + 1;
		if (quiet >= QUIET_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	// Offer one request and hold it until accepted; an idle gap, if drawn, comes first.
	task automatic send_byte(input logic [7:0] b, input logic last);
		if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
			while ($urandom_range(99) < send_idle_pct)
				@(posedge clk);
		end
		in_valid <= 1'b1;
		in_byte <= b;
		last_in_call <= last;
		do @(posedge clk); while (!in_ready);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (sb.owed.size() != 0)
			@(posedge clk);
	endtask

	// The limit is only changed once the block has gone quiet.
	task automatic set_limit(input logic [23:0] value);
		drain();
		repeat (SETTLE_CYCLES) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_data <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		sb.limit = value;
	endtask

	task automatic send_match(input logic [11:0] src, input int len);
		send_byte(src[7:0], 1'b0);
		if (len >= 18) begin
			send_byte({lzss_pkg::LEN_CODE_EXT, src[11:8]}, 1'b0);
			send_byte(8'(len - 18), 1'b0);
		end else begin
			send_byte({4'(len - 3), src[11:8]}, 1'b0);
		end
	endtask

	// Random bytes parse as well-formed tokens on their own; an early end of
	// call now and then cuts a token short.
	task automatic random_stream(input int count);
		for (int k = 0; k < count; k++)
			send_byte(8'($urandom_range(255)), $urandom_range(24) == 0);
		send_byte(8'($urandom_range(255)), 1'b1);
	endtask

	initial begin
		logic [11:0] wp;
		sb = new();
		sb.clear();
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_byte = '0;
		last_in_call = 1'b0;
		out_ready = 1'b0;
		cfg_we = 1'b0;
		cfg_data = '0;
		send_idle_pct = 0;
		stall_pct = 0;
		hold_cycles = 0;
		quiet = 0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		set_limit(lzss_pkg::LIMIT_RESET);

		// Eight literals first, then long matches that reach back over what is written.
		send_byte(8'h00, 1'b0);
		for (int k = 0; k < 8; k++)
			send_byte(8'($urandom_range(255)), 1'b0);
		wp = 12'd8;
		for (int k = 0; k < 16; k++) begin
			if (k % 8 == 0)
				send_byte(8'hFF, 1'b0);
			send_match(wp - 12'($urandom_range(int'(wp) - 1, 1)), 273);
			wp = wp + 12'd273;
		end
		send_byte(8'h00, 1'b1);

		// Directed tokens: field extremes, shortest and longest matches and the
		// extension byte at both ends, then calls that end in the middle of a token.
		send_byte(8'h55, 1'b0);
		send_match(12'hFFF, 3);
		send_byte(8'h00, 1'b0);
		send_match(12'h000, 17);
		send_byte(8'hFF, 1'b0);
		send_match(12'h123, 18);
		send_byte(8'hA5, 1'b0);
		send_match(12'h800, 273);
		send_byte(8'h5A, 1'b1);
		send_byte(8'h01, 1'b1);
		send_byte(8'h01, 1'b0);
		send_byte(8'h34, 1'b1);
		send_byte(8'h01, 1'b0);
		send_byte(8'h34, 1'b0);
		send_byte(8'hF7, 1'b1);

		// A zero limit suppresses all output while literals still fill the ring.
		set_limit(24'd0);
		send_idle_pct = 75;
		random_stream(50);

		set_limit(24'd37);
		send_idle_pct = 0;
		stall_pct = 75;
		random_stream(55);

		set_limit(24'd1);
		send_idle_pct = 9;
		stall_pct = 9;
		random_stream(55);

		// Long receiver hold-off while the sender keeps offering requests.
		set_limit(lzss_pkg::LIMIT_RESET);
		send_idle_pct = 0;
		stall_pct = 0;
		hold_cycles = 3000;
		random_stream(60);
		drain();

		set_limit(24'($urandom_range(300, 2)));
		random_stream(55);

		set_limit(lzss_pkg::LIMIT_RESET);
		send_idle_pct = 9;
		stall_pct = 9;
		random_stream(50);

		drain();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (sb.mismatches == 0 && sb.owed.size() == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end
endmodule
